@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the echo mixer.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/ffem_pkg.sv @@
// Package of the feedforward echo mixer: field widths, fixed-point constants
// and register index codes. No dependencies.
package ffem_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DELAY_W  = 15;
   localparam int GAIN_W   = 16;
   localparam int COUNT_W  = 16;
   localparam int CSR_W    = 16;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 15'd3000;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd0;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

   // 1.0 in Q2.14 and 0.3 in Q0.16
   localparam logic signed [15:0] GAIN_ONE        = 16'sd16384;
   localparam logic [15:0]        POINT_THREE_Q16 = 16'd19661;
   localparam int                 FRAC_BITS       = 14;

   typedef enum logic [0:0] {
      CSR_ECHO_DELAY = 1'b0,
      CSR_ECHO_GAIN  = 1'b1
   } csr_index_type;

endpackage

@@ rtl/core/ffem_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the sample history of the echo mixer; no package dependency.
module ffem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/feedforward_echo_mixer.sv @@
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// req      | req_valid, req_stall, req_sample_in,    | in
//          | req_buffer_start                        |
// rsp      | rsp_valid, rsp_stall, rsp_sample_out    | out
// csr      | csr_wr_en, csr_index, csr_wdata         | in
//
// One sample per cycle sustained while rsp_stall does not hold the output; a result
// reaches the output register through the history RAM read at the transfer edge, the
// multiply stage, then sum/scale/clamp into the output register.
// The history RAM has one write and one read port, used once per sample.
// Synchronous reset clears pointer, count, stage valids and configuration registers
// and holds req_stall high; the history RAM needs no clearing pass. A stalled result
// holds the output register while empty stages upstream keep taking samples.
//
// Depends on ffem_pkg, ffem_ram and assert_macros.svh.
`include "assert_macros.svh"

module feedforward_echo_mixer #(
   parameter int MAX_DELAY = 32768
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ffem_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                req_buffer_start,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ffem_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                csr_wr_en,
   input  logic [0:0]                          csr_index,
   input  logic [ffem_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int AW = $clog2(MAX_DELAY);
   localparam int CW = ((AW > ffem_pkg::DELAY_W) ? AW : ffem_pkg::DELAY_W) + 2;
   localparam int SW = ffem_pkg::SAMPLE_W;
   localparam int PW = 2 * SW + 2;

   // ---------------- configuration ----------------
   logic [ffem_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [ffem_pkg::GAIN_W-1:0]  gain_ff, gain_in;
   logic signed [SW-1:0]         dry_ff, dry_in;
   logic [31:0]                  gain_scaled;

   always_comb begin
      delay_in = delay_ff;
      gain_in  = gain_ff;
      if (csr_wr_en) begin
         unique case (ffem_pkg::csr_index_type'(csr_index))
            ffem_pkg::CSR_ECHO_DELAY: delay_in = csr_wdata[ffem_pkg::DELAY_W-1:0];
            ffem_pkg::CSR_ECHO_GAIN:  gain_in  = csr_wdata[ffem_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // dry = 1.0 - 0.3 * gain, refreshed every cycle from the gain register
   assign gain_scaled = 32'(gain_ff) * 32'(ffem_pkg::POINT_THREE_Q16);
   assign dry_in      = ffem_pkg::GAIN_ONE - $signed({1'b0, gain_scaled[30:16]});

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= ffem_pkg::DELAY_RESET;
         gain_ff  <= ffem_pkg::GAIN_RESET;
         dry_ff   <= ffem_pkg::GAIN_ONE;
      end else begin
         delay_ff <= delay_in;
         gain_ff  <= gain_in;
         dry_ff   <= dry_in;
      end
   end

   // ---------------- flow control ----------------
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic out_free, s2_free, s1_free, req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_stall  = reset || !s1_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = s1_free  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_free  ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   // ---------------- stage 0: address, count, RAM access ----------------
   logic [AW-1:0]                wp_ff, wp_in;
   logic [ffem_pkg::COUNT_W-1:0] seen_ff, seen_in, seen_cur;
   logic                         echo_on;
   logic [CW-1:0]                rd_sum, rd_wrap;
   logic [AW-1:0]                rd_addr;
   logic [SW-1:0]                ram_q;

   assign seen_cur = req_buffer_start ? '0 : seen_ff;
   assign echo_on  = (seen_cur >= ffem_pkg::COUNT_W'(delay_ff))
                     && (CW'(delay_ff) < CW'(MAX_DELAY));

   // read slot = (wp - delay) modulo MAX_DELAY
   assign rd_sum  = CW'(wp_ff) + CW'(MAX_DELAY) - CW'(delay_ff);
   assign rd_wrap = (rd_sum >= CW'(MAX_DELAY)) ? rd_sum - CW'(MAX_DELAY) : rd_sum;
   assign rd_addr = echo_on ? rd_wrap[AW-1:0] : wp_ff;

   always_comb begin
      wp_in   = wp_ff;
      seen_in = seen_ff;
      if (req_accept) begin
         wp_in   = (wp_ff == AW'(MAX_DELAY - 1)) ? '0 : wp_ff + 1'b1;
         seen_in = (seen_cur == ffem_pkg::COUNT_MAX) ? seen_cur : seen_cur + 1'b1;
      end
   end

   ffem_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_DELAY)
   ) u_history (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (wp_ff),
      .wr_data (req_sample_in),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // ---------------- stage 1: products ----------------
   logic signed [SW-1:0] s1_x_ff, s1_x_in;
   logic                 s1_echo_ff, s1_echo_in;
   logic                 s1_self_ff, s1_self_in;
   logic signed [SW-1:0] delayed;
   logic signed [SW:0]   gain_s;

   assign s1_x_in    = s1_free ? req_sample_in : s1_x_ff;
   assign s1_echo_in = s1_free ? echo_on : s1_echo_ff;
   assign s1_self_in = s1_free ? (delay_ff == '0) : s1_self_ff;

   // zero delay mixes the current sample with itself
   assign delayed = s1_self_ff ? s1_x_ff : $signed(ram_q);
   assign gain_s  = $signed({1'b0, gain_ff});

   logic signed [2*SW-1:0] s2_pdry_ff, s2_pdry_in;
   logic signed [2*SW:0]   s2_pecho_ff, s2_pecho_in;
   logic signed [SW-1:0]   s2_x_ff, s2_x_in;
   logic                   s2_echo_ff, s2_echo_in;

   always_comb begin
      s2_pdry_in  = s2_pdry_ff;
      s2_pecho_in = s2_pecho_ff;
      s2_x_in     = s2_x_ff;
      s2_echo_in  = s2_echo_ff;
      if (s2_free) begin
         s2_pdry_in  = dry_ff * s1_x_ff;
         s2_pecho_in = gain_s * delayed;
         s2_x_in     = s1_x_ff;
         s2_echo_in  = s1_echo_ff;
      end
   end

   // ---------------- stage 2: sum, scale toward zero, clamp ----------------
   logic signed [PW-1:0] mix_sum, mix_bias, mix_q;
   logic signed [SW-1:0] mix_sat;
   logic signed [SW-1:0] rsp_sample_ff, rsp_sample_in;

   assign mix_sum  = PW'(s2_pdry_ff) + PW'(s2_pecho_ff);
   assign mix_bias = mix_sum
                     + (mix_sum[PW-1] ? PW'((1 << ffem_pkg::FRAC_BITS) - 1) : PW'(0));
   assign mix_q    = mix_bias >>> ffem_pkg::FRAC_BITS;

   always_comb begin
      if (mix_q > PW'(32767)) begin
         mix_sat = 16'sh7FFF;
      end else if (mix_q < -PW'(32768)) begin
         mix_sat = 16'sh8000;
      end else begin
         mix_sat = mix_q[SW-1:0];
      end
   end

   assign rsp_sample_in = out_free ? (s2_echo_ff ? mix_sat : s2_x_ff) : rsp_sample_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         seen_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff       <= s1_x_in;
      s1_echo_ff    <= s1_echo_in;
      s1_self_ff    <= s1_self_in;
      s2_pdry_ff    <= s2_pdry_in;
      s2_pecho_ff   <= s2_pecho_in;
      s2_x_ff       <= s2_x_in;
      s2_echo_ff    <= s2_echo_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // ---------------- assertions ----------------
   `ASSERT_NXT(a_seen_step, clock, reset,
      req_accept && !req_buffer_start && (seen_ff != ffem_pkg::COUNT_MAX),
      seen_ff == $past(seen_ff) + 1'b1)
   `ASSERT_NXT(a_wp_hold, clock, reset, !req_accept, $stable(wp_ff))
   `ASSERT_NXT(a_ram_hold, clock, reset, s1_valid_ff && !s2_free,
      s1_valid_ff && $stable(ram_q) && $stable(s1_x_ff))

endmodule
